// ===== rtl/dad_pkg.sv =====
// Package for the date advance block: word types, state encoding and calendar helpers.
// Used by dad_core, date_add_days_top and the checker dad_chk.
package dad_pkg;

  localparam int RestW = 21;
  localparam int YearW = 13;

  typedef struct packed {
    logic [11:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
    logic [19:0] days_to_add;
  } dad_in_t;

  typedef struct packed {
    logic [12:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [4:0]  end_hour;
    logic [5:0]  end_minute;
    logic [5:0]  end_second;
  } dad_out_t;

  typedef struct packed {
    logic start;
    logic ack;
  } dad_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } dad_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENT,
    ST_MACC,
    ST_ADD,
    ST_YEAR,
    ST_MON,
    ST_DONE
  } dad_state_t;

  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonApr = 4'd4;
  localparam logic [3:0] MonJun = 4'd6;
  localparam logic [3:0] MonSep = 4'd9;
  localparam logic [3:0] MonNov = 4'd11;
  localparam logic [3:0] MonDec = 4'd12;

  // Days in month m; months outside 1..12 other than the named ones count as 31.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      case (m)
        MonFeb:                         len = leap ? 5'd29 : 5'd28;
        MonApr, MonJun, MonSep, MonNov: len = 5'd30;
        default:                        len = 5'd31;
      endcase
      return len;
    end
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

// ===== rtl/date_add_days_top.sv =====
// Top level of the date advance block: input handshake, core and output register.
// Depends on dad_pkg and dad_core.
//
// Usage: the input channel (in_valid, in_ready, in_data) takes one word holding a
// start date, a time of day and a day count. The result channel (out_valid,
// out_ready, out_data) returns one word per input word with the advanced date and
// the time of day copied unchanged.
// The core works on one word at a time, so in_ready is high only while it is idle.
// From acceptance to out_valid the core walks through the century split of
// start_year by repeated subtraction of 100, the months before the start month,
// the whole years crossed and the month steps in the final year. Each step uses
// the single shared 21-bit add/subtract unit, which does one step per cycle.
// The finished result moves into an output register, so the core goes idle and
// can accept the next word while the result waits for out_ready. If the receiver
// stalls longer, the next result is held in the core until the register frees.
// Reset (rst_n low, synchronous) returns the core to idle and drops out_valid;
// no clearing pass is needed.
module date_add_days_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dad_pkg::dad_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dad_pkg::dad_out_t out_data
);
  import dad_pkg::*;

  dad_ctl_t ctl;
  dad_sts_t sts;
  dad_out_t result;

  logic     out_valid_r, out_valid_nxt;
  dad_out_t out_data_r;
  logic     take;

  dad_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .in_data (in_data),
    .sts     (sts),
    .result  (result)
  );

  // The core accepts a word only while idle.
  assign in_ready  = sts.idle;
  assign ctl.start = in_valid && in_ready;

  // A finished result moves to the output register when it is empty or draining.
  assign take    = sts.done && (!out_valid_r || out_ready);
  assign ctl.ack = take;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/dad_core.sv =====
// Sequencer and shared add/subtract unit that advance one date by a day count.
// Depends on dad_pkg for word types, state encoding and month/year lengths.
module dad_core (
  input  logic              clk,
  input  logic              rst_n,
  input  dad_pkg::dad_ctl_t ctl,
  input  dad_pkg::dad_in_t  in_data,
  output dad_pkg::dad_sts_t sts,
  output dad_pkg::dad_out_t result
);
  import dad_pkg::*;

  dad_state_t       state_r, state_nxt;
  dad_in_t          in_r, in_nxt;
  logic [RestW-1:0] rest_r, rest_nxt;
  logic [YearW-1:0] year_r, year_nxt;
  logic [3:0]       m_r, m_nxt;
  logic [6:0]       c100_r, c100_nxt;   // year modulo 100
  logic [1:0]       cq_r, cq_nxt;       // century count modulo 4

  logic             leap;
  logic             sub;
  logic [RestW-1:0] opb;
  logic [RestW:0]   opb_eff;
  logic [RestW:0]   res;
  logic             neg;
  logic             gt;                 // rest_r strictly greater than opb

  // Leap rule with the modulo counters that track year_r.
  assign leap = ((year_r[1:0] == 2'd0) && (c100_r != 7'd0)) ||
                ((c100_r == 7'd0) && (cq_r == 2'd0));

  // Operand selection for the single shared adder.
  always_comb begin
    sub = 1'b1;
    opb = '0;
    unique case (state_r)
      ST_CENT: opb = RestW'(100);
      ST_MACC: begin
        sub = 1'b0;
        opb = RestW'(month_len(m_r, leap));
      end
      ST_ADD: begin
        sub = 1'b0;
        opb = RestW'(in_r.days_to_add);
      end
      ST_YEAR: opb = RestW'(year_len(leap));
      ST_MON:  opb = RestW'(month_len(m_r, leap));
      default: opb = '0;
    endcase
  end

  assign opb_eff = sub ? ~{1'b0, opb} : {1'b0, opb};
  assign res     = {1'b0, rest_r} + opb_eff + {{RestW{1'b0}}, sub};
  assign neg     = res[RestW];
  assign gt      = !neg && (res[RestW-1:0] != '0);

  always_comb begin
    state_nxt = state_r;
    in_nxt    = in_r;
    rest_nxt  = rest_r;
    year_nxt  = year_r;
    m_nxt     = m_r;
    c100_nxt  = c100_r;
    cq_nxt    = cq_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) begin
          in_nxt    = in_data;
          rest_nxt  = RestW'(in_data.start_year);
          year_nxt  = YearW'(in_data.start_year);
          cq_nxt    = 2'd0;
          state_nxt = ST_CENT;
        end
      end
      // Split the start year into centuries and remainder by repeated subtraction.
      ST_CENT: begin
        if (!neg) begin
          rest_nxt = res[RestW-1:0];
          cq_nxt   = cq_r + 2'd1;
        end else begin
          c100_nxt  = rest_r[6:0];
          rest_nxt  = RestW'(in_r.start_day);
          m_nxt     = 4'd1;
          state_nxt = ST_MACC;
        end
      end
      // Ordinal day: add the lengths of the months before the start month.
      ST_MACC: begin
        if ((m_r < in_r.start_month) && (m_r <= MonDec)) begin
          rest_nxt = res[RestW-1:0];
          m_nxt    = m_r + 4'd1;
        end else begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        rest_nxt  = res[RestW-1:0];
        state_nxt = ST_YEAR;
      end
      // Take off whole years; the modulo counters follow the year.
      ST_YEAR: begin
        if (gt) begin
          rest_nxt = res[RestW-1:0];
          year_nxt = year_r + YearW'(1);
          if (c100_r == 7'd99) begin
            c100_nxt = 7'd0;
            cq_nxt   = cq_r + 2'd1;
          end else begin
            c100_nxt = c100_r + 7'd1;
          end
        end else begin
          m_nxt     = 4'd1;
          state_nxt = ST_MON;
        end
      end
      ST_MON: begin
        if ((m_r < MonDec) && gt) begin
          rest_nxt = res[RestW-1:0];
          m_nxt    = m_r + 4'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctl.ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    rest_r <= rest_nxt;
    year_r <= year_nxt;
    m_r    <= m_nxt;
    c100_r <= c100_nxt;
    cq_r   <= cq_nxt;
  end

  assign sts.idle = (state_r == ST_IDLE);
  assign sts.done = (state_r == ST_DONE);

  assign result.end_year   = year_r;
  assign result.end_month  = m_r;
  assign result.end_day    = rest_r[4:0];
  assign result.end_hour   = in_r.start_hour;
  assign result.end_minute = in_r.start_minute;
  assign result.end_second = in_r.start_second;

endmodule

// ===== rtl/dad_chk.sv =====
// Port-level checker for date_add_days_top, attached by the bind statement below.
// Depends on dad_pkg for the word types.
module dad_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input dad_pkg::dad_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input dad_pkg::dad_out_t out_data
);
  import dad_pkg::*;

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  // The block works on one word at a time, so it is busy right after acceptance.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word is in progress");

  // Every delivered date has a real month and a day no greater than 31.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.end_month >= 4'd1) && (out_data.end_month <= MonDec) &&
                  (out_data.end_day <= 5'd31))
    else $error("result month or day out of range");

endmodule

bind date_add_days_top dad_chk u_dad_chk (.*);
